[rtl/core/scancode_set1_to_ascii_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Set-1 scancode decoder
// Each macro expands to a labeled concurrent assertion, or to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_TO_ASCII_DECODER_DEFINES_SVH
`define SCANCODE_SET1_TO_ASCII_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SCS1_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs1 assertion failed");
// next-cycle implication
`define SCS1_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs1 assertion failed");
`else
`define SCS1_ASSERT_IMP(name, clk, rst, ante, cons)
`define SCS1_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

[rtl/core/scs1_pkg.sv]
// ----------------------------------------------------------------------------
// scs1_pkg
// Types, key codes and keymap table for the Set-1 scancode decoder.
// ----------------------------------------------------------------------------
package scs1_pkg;

  localparam int KeyW    = 7;
  localparam int CharW   = 7;
  localparam int MaxRun  = 4;
  localparam int CountW  = 3;
  localparam int IdxW    = 2;

  // prefix bytes
  localparam logic [7:0] CodeExtPrefix   = 8'hE0;
  localparam logic [7:0] CodePausePrefix = 8'hE1;

  // key numbers (low seven bits of the scancode)
  localparam logic [KeyW-1:0] KeyEsc    = 7'h01;
  localparam logic [KeyW-1:0] KeyBksp   = 7'h0E;
  localparam logic [KeyW-1:0] KeyEnter  = 7'h1C;
  localparam logic [KeyW-1:0] KeyCtrl   = 7'h1D;
  localparam logic [KeyW-1:0] KeyLShift = 7'h2A;
  localparam logic [KeyW-1:0] KeyRShift = 7'h36;
  localparam logic [KeyW-1:0] KeyAlt    = 7'h38;
  localparam logic [KeyW-1:0] KeyCaps   = 7'h3A;
  localparam logic [KeyW-1:0] KeyNum    = 7'h45;
  localparam logic [KeyW-1:0] KeyScroll = 7'h46;
  localparam logic [KeyW-1:0] KeyHome   = 7'h47;
  localparam logic [KeyW-1:0] KeyUp     = 7'h48;
  localparam logic [KeyW-1:0] KeyPgUp   = 7'h49;
  localparam logic [KeyW-1:0] KeyLeft   = 7'h4B;
  localparam logic [KeyW-1:0] KeyRight  = 7'h4D;
  localparam logic [KeyW-1:0] KeyEnd    = 7'h4F;
  localparam logic [KeyW-1:0] KeyDown   = 7'h50;
  localparam logic [KeyW-1:0] KeyPgDn   = 7'h51;
  localparam logic [KeyW-1:0] KeyIns    = 7'h52;
  localparam logic [KeyW-1:0] KeyDel    = 7'h53;

  // ASCII values
  localparam logic [CharW-1:0] AsciiBs     = 7'h08;
  localparam logic [CharW-1:0] AsciiLf     = 7'h0A;
  localparam logic [CharW-1:0] AsciiEsc    = 7'h1B;
  localparam logic [CharW-1:0] AsciiLbrack = 7'h5B;
  localparam logic [CharW-1:0] AsciiTilde  = 7'h7E;
  localparam logic [CharW-1:0] CaseBit     = 7'h20;

  // final byte of the ANSI sequences
  localparam logic [CharW-1:0] SeqUp    = 7'h41; // A
  localparam logic [CharW-1:0] SeqDown  = 7'h42; // B
  localparam logic [CharW-1:0] SeqRight = 7'h43; // C
  localparam logic [CharW-1:0] SeqLeft  = 7'h44; // D
  localparam logic [CharW-1:0] SeqEnd   = 7'h46; // F
  localparam logic [CharW-1:0] SeqHome  = 7'h48; // H
  localparam logic [CharW-1:0] SeqIns   = 7'h32; // 2
  localparam logic [CharW-1:0] SeqDel   = 7'h33; // 3
  localparam logic [CharW-1:0] SeqPgUp  = 7'h35; // 5
  localparam logic [CharW-1:0] SeqPgDn  = 7'h36; // 6

  typedef struct packed {
    logic left_shift_held;
    logic right_shift_held;
    logic left_ctrl_held;
    logic right_ctrl_held;
    logic left_alt_held;
    logic right_alt_held;
    logic caps_lock_on;
    logic num_lock_on;
    logic scroll_lock_on;
    logic prefix_pending;
  } flags_t;

  typedef struct packed {
    logic [CharW-1:0] shifted;
    logic [CharW-1:0] plain;
  } keymap_entry_t;

  typedef struct packed {
    logic [CountW-1:0]            count;  // 0..4 bytes
    logic [MaxRun-1:0][CharW-1:0] bytes;  // bytes[0] goes out first
  } run_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= 7'h61) && (c <= 7'h7A)) || ((c >= 7'h41) && (c <= 7'h5A));
  endfunction

  // {shifted, plain}; keys past the table and empty slots read as zero
  function automatic keymap_entry_t keymap_lookup(input logic [KeyW-1:0] key);
    keymap_entry_t e;
    e = '0;
    unique case (key)
      7'd2:  e = '{7'h21, 7'h31};
      7'd3:  e = '{7'h40, 7'h32};
      7'd4:  e = '{7'h23, 7'h33};
      7'd5:  e = '{7'h24, 7'h34};
      7'd6:  e = '{7'h25, 7'h35};
      7'd7:  e = '{7'h5E, 7'h36};
      7'd8:  e = '{7'h26, 7'h37};
      7'd9:  e = '{7'h2A, 7'h38};
      7'd10: e = '{7'h28, 7'h39};
      7'd11: e = '{7'h29, 7'h30};
      7'd12: e = '{7'h5F, 7'h2D};
      7'd13: e = '{7'h2B, 7'h3D};
      7'd14: e = '{7'h08, 7'h08};
      7'd15: e = '{7'h09, 7'h09};
      7'd16: e = '{7'h51, 7'h71};
      7'd17: e = '{7'h57, 7'h77};
      7'd18: e = '{7'h45, 7'h65};
      7'd19: e = '{7'h52, 7'h72};
      7'd20: e = '{7'h54, 7'h74};
      7'd21: e = '{7'h59, 7'h79};
      7'd22: e = '{7'h55, 7'h75};
      7'd23: e = '{7'h49, 7'h69};
      7'd24: e = '{7'h4F, 7'h6F};
      7'd25: e = '{7'h50, 7'h70};
      7'd26: e = '{7'h7B, 7'h5B};
      7'd27: e = '{7'h7D, 7'h5D};
      7'd28: e = '{7'h0A, 7'h0A};
      7'd30: e = '{7'h41, 7'h61};
      7'd31: e = '{7'h53, 7'h73};
      7'd32: e = '{7'h44, 7'h64};
      7'd33: e = '{7'h46, 7'h66};
      7'd34: e = '{7'h47, 7'h67};
      7'd35: e = '{7'h48, 7'h68};
      7'd36: e = '{7'h4A, 7'h6A};
      7'd37: e = '{7'h4B, 7'h6B};
      7'd38: e = '{7'h4C, 7'h6C};
      7'd39: e = '{7'h3A, 7'h3B};
      7'd40: e = '{7'h22, 7'h27};
      7'd41: e = '{7'h7E, 7'h60};
      7'd43: e = '{7'h7C, 7'h5C};
      7'd44: e = '{7'h5A, 7'h7A};
      7'd45: e = '{7'h58, 7'h78};
      7'd46: e = '{7'h43, 7'h63};
      7'd47: e = '{7'h56, 7'h76};
      7'd48: e = '{7'h42, 7'h62};
      7'd49: e = '{7'h4E, 7'h6E};
      7'd50: e = '{7'h4D, 7'h6D};
      7'd51: e = '{7'h3C, 7'h2C};
      7'd52: e = '{7'h3E, 7'h2E};
      7'd53: e = '{7'h3F, 7'h2F};
      7'd55: e = '{7'h2A, 7'h2A};
      7'd57: e = '{7'h20, 7'h20};
      7'd72: e = '{7'h37, 7'h37};
      7'd73: e = '{7'h38, 7'h38};
      7'd74: e = '{7'h39, 7'h39};
      7'd75: e = '{7'h2D, 7'h2D};
      7'd76: e = '{7'h34, 7'h34};
      7'd77: e = '{7'h35, 7'h35};
      7'd78: e = '{7'h36, 7'h36};
      7'd79: e = '{7'h2B, 7'h2B};
      7'd80: e = '{7'h31, 7'h31};
      7'd81: e = '{7'h32, 7'h32};
      7'd82: e = '{7'h33, 7'h33};
      7'd83: e = '{7'h30, 7'h30};
      7'd84: e = '{7'h2E, 7'h2E};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[rtl/core/scs1_keymap_rom.sv]
// ----------------------------------------------------------------------------
// scs1_keymap_rom
// Plain/shifted keymap ROM with a registered read port.
// ----------------------------------------------------------------------------
module scs1_keymap_rom import scs1_pkg::*; (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [KeyW-1:0] rd_addr,
  output keymap_entry_t   rd_data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= keymap_lookup(rd_addr);
    end
  end

endmodule

[rtl/core/scs1_decode.sv]
// ----------------------------------------------------------------------------
// scs1_decode
// Decodes one scancode against the current flags: next flags and output run.
// ----------------------------------------------------------------------------
module scs1_decode import scs1_pkg::*; (
  input  logic [7:0]    code,
  input  flags_t        flags,
  input  keymap_entry_t entry,
  output flags_t        flags_next,
  output run_t          run
);

  logic             key_up;
  logic [KeyW-1:0]  key;
  logic [CharW-1:0] ch_sel;
  logic [CharW-1:0] ch_caps;
  logic [CharW-1:0] ch_final;

  assign key_up = code[7];
  assign key    = code[KeyW-1:0];

  // ordinary key: table pick, caps flips letter case, ctrl folds letters to 1..26
  assign ch_sel  = (flags.left_shift_held || flags.right_shift_held) ? entry.shifted
                                                                     : entry.plain;
  assign ch_caps = (flags.caps_lock_on && is_letter(ch_sel)) ? (ch_sel ^ CaseBit) : ch_sel;
  assign ch_final = ((flags.left_ctrl_held || flags.right_ctrl_held) && is_letter(ch_caps))
                    ? {2'b00, ch_caps[4:0]} : ch_caps;

  always_comb begin
    flags_next   = flags;
    run.count    = '0;
    run.bytes[0] = AsciiEsc;
    run.bytes[1] = AsciiLbrack;
    run.bytes[2] = '0;
    run.bytes[3] = AsciiTilde;

    priority if (code == CodeExtPrefix) begin
      flags_next.prefix_pending = 1'b1;
    end else if (code == CodePausePrefix) begin
      flags_next.prefix_pending = 1'b0;
    end else if (flags.prefix_pending) begin
      flags_next.prefix_pending = 1'b0;
      if (key == KeyCtrl) begin
        flags_next.right_ctrl_held = !key_up;
      end else if (key == KeyAlt) begin
        flags_next.right_alt_held = !key_up;
      end else if (!key_up) begin
        unique case (key)
          KeyUp:    begin run.bytes[2] = SeqUp;    run.count = 3'd3; end
          KeyDown:  begin run.bytes[2] = SeqDown;  run.count = 3'd3; end
          KeyRight: begin run.bytes[2] = SeqRight; run.count = 3'd3; end
          KeyLeft:  begin run.bytes[2] = SeqLeft;  run.count = 3'd3; end
          KeyHome:  begin run.bytes[2] = SeqHome;  run.count = 3'd3; end
          KeyEnd:   begin run.bytes[2] = SeqEnd;   run.count = 3'd3; end
          KeyIns:   begin run.bytes[2] = SeqIns;   run.count = 3'd4; end
          KeyDel:   begin run.bytes[2] = SeqDel;   run.count = 3'd4; end
          KeyPgUp:  begin run.bytes[2] = SeqPgUp;  run.count = 3'd4; end
          KeyPgDn:  begin run.bytes[2] = SeqPgDn;  run.count = 3'd4; end
          default: ;
        endcase
      end
    end else if (key_up) begin
      unique case (key)
        KeyLShift: flags_next.left_shift_held  = 1'b0;
        KeyRShift: flags_next.right_shift_held = 1'b0;
        KeyCtrl:   flags_next.left_ctrl_held   = 1'b0;
        KeyAlt:    flags_next.left_alt_held    = 1'b0;
        default: ;
      endcase
    end else begin
      unique case (key)
        KeyLShift: flags_next.left_shift_held  = 1'b1;
        KeyRShift: flags_next.right_shift_held = 1'b1;
        KeyCtrl:   flags_next.left_ctrl_held   = 1'b1;
        KeyAlt:    flags_next.left_alt_held    = 1'b1;
        KeyCaps:   flags_next.caps_lock_on     = !flags.caps_lock_on;
        KeyNum:    flags_next.num_lock_on      = !flags.num_lock_on;
        KeyScroll: flags_next.scroll_lock_on   = !flags.scroll_lock_on;
        KeyEsc:    begin run.bytes[0] = AsciiEsc; run.count = 3'd1; end
        KeyBksp:   begin run.bytes[0] = AsciiBs;  run.count = 3'd1; end
        KeyEnter:  begin run.bytes[0] = AsciiLf;  run.count = 3'd1; end
        default: begin
          if (ch_sel != '0) begin
            run.bytes[0] = ch_final;
            run.count    = 3'd1;
          end
        end
      endcase
    end
  end

endmodule

[rtl/core/scs1_serializer.sv]
// ----------------------------------------------------------------------------
// scs1_serializer
// Holds one decoded run and sends its bytes out one per transaction.
// ----------------------------------------------------------------------------
module scs1_serializer import scs1_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  input  run_t             load_run,
  output logic             load_ready,
  output logic             char_valid,
  input  logic             char_ready,
  output logic [CharW-1:0] out_char,
  output logic             last_of_run
);

  logic                         busy;
  logic [IdxW-1:0]              idx;
  logic [IdxW-1:0]              last_idx;
  logic [MaxRun-1:0][CharW-1:0] bytes;
  logic                         load;

  assign char_valid  = busy;
  assign out_char    = bytes[idx];
  assign last_of_run = (idx == last_idx);
  // free now, or freed by the final byte leaving this cycle
  assign load_ready  = !busy || (char_ready && last_of_run);
  assign load        = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && char_ready) begin
      if (last_of_run) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes    <= load_run.bytes;
      last_idx <= IdxW'(load_run.count - 3'd1);
    end
  end

endmodule

[rtl/core/scancode_set1_to_ascii_decoder.sv]
// A scancode is registered in stage 1 with the ROM read, then loaded into the serializer.
// Throughput: one scancode per cycle when each yields at most one byte and char_ready is
//   high; a run (at most four bytes) holds the output register until its last byte is taken.
// Rate is set by the single-byte output port draining each run.
// Reset (rst, synchronous) clears all modifier/lock/prefix flags and empties
//   both pipeline stages; the keymap ROM's read register is not reset.
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder
// Set-1 scancode to ASCII decoder: keymap ROM read, decode with flag update,
// and a run serializer.
// ----------------------------------------------------------------------------
`include "scancode_set1_to_ascii_decoder_defines.svh"

module scancode_set1_to_ascii_decoder import scs1_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             scan_valid,
  output logic             scan_ready,
  input  logic [7:0]       scan_code,
  output logic             char_valid,
  input  logic             char_ready,
  output logic [CharW-1:0] out_char,
  output logic             last_of_run
);

  // Stage 1: scancode register, lined up with the registered ROM read.
  logic          s1_valid;
  logic [7:0]    s1_code;
  logic          s1_advance;
  logic          scan_xact;
  keymap_entry_t rom_entry;

  // Flag register; only the stage-1 decode reads and writes it, and stage 1
  // retires in order, so no forwarding is needed.
  flags_t flags;
  flags_t flags_next;

  run_t run;
  logic load_ready;
  logic load_valid;

  assign scan_xact  = scan_valid && scan_ready;
  // a scancode with no output retires without waiting on the serializer
  assign load_valid = s1_valid && (run.count != '0);
  assign s1_advance = s1_valid && ((run.count == '0) || load_ready);
  assign scan_ready = !s1_valid || s1_advance;

  // ROM read is issued with the input transaction and held while stage 1 stalls
  scs1_keymap_rom u_rom (
    .clk     (clk),
    .rd_en   (scan_xact),
    .rd_addr (scan_code[KeyW-1:0]),
    .rd_data (rom_entry)
  );

  scs1_decode u_decode (
    .code       (s1_code),
    .flags      (flags),
    .entry      (rom_entry),
    .flags_next (flags_next),
    .run        (run)
  );

  scs1_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (load_valid),
    .load_run    (run),
    .load_ready  (load_ready),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      flags    <= '0;
    end else begin
      if (scan_xact) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_xact) begin
      s1_code <= scan_code;
    end
  end

  // Stalled stage 1 keeps its scancode.
  `SCS1_ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !s1_advance,
                   s1_valid && $stable(s1_code))
  // An E0 prefix arms the prefix flag.
  `SCS1_ASSERT_NXT(a_prefix_set, clk, rst, s1_advance && (s1_code == CodeExtPrefix),
                   flags.prefix_pending)
  // Any other decoded byte leaves the prefix flag clear.
  `SCS1_ASSERT_NXT(a_prefix_clr, clk, rst, s1_advance && (s1_code != CodeExtPrefix),
                   !flags.prefix_pending)
  // A run does not end early: a non-final byte taken means more follow.
  `SCS1_ASSERT_NXT(a_run_cont, clk, rst, char_valid && char_ready && !last_of_run,
                   char_valid)

endmodule
